>>> rtl/aks_pkg.sv
package aks_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned StdW   = 28;
    localparam int unsigned NormW  = 17;
    localparam int unsigned GainW  = 31;
    localparam int unsigned CntW   = 5;

    localparam logic signed [DataW-1:0] InitEstimateDef = '0;

    localparam logic [CfgIdxW-1:0] RegInitP    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegMeasN    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegQLow     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegQHigh    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStdLow   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegStdHigh  = 3'd5;
    localparam logic [CfgIdxW-1:0] RegQStep    = 3'd6;
    localparam logic [CfgIdxW-1:0] RegVarW     = 3'd7;

    localparam logic [31:0] InitPRst   = 32'd16777216;
    localparam logic [31:0] MeasNRst   = 32'd167772;
    localparam logic [31:0] QLowRst    = 32'd1678;
    localparam logic [31:0] QHighRst   = 32'd8388608;
    localparam logic [31:0] StdLowRst  = 32'd168;
    localparam logic [31:0] StdHighRst = 32'd8388608;
    localparam logic [31:0] QStepRst   = 32'd16777;
    localparam logic [15:0] VarWRst    = 16'd62259;

    localparam logic [CntW-1:0] NormSteps = 5'd17;
    localparam logic [CntW-1:0] GainSteps = 5'd31;
    localparam logic [CntW-1:0] SqrtSteps = 5'd28;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_RVA, S_RVB, S_RVC, S_SQRT, S_NORM, S_NDIV,
        S_SM1, S_SM2, S_SM3, S_LIM1, S_LIM2, S_GAIN, S_GDIV,
        S_XM1, S_XM2, S_XN, S_EV, S_EU, S_FIN
    } t_state;

    typedef struct packed {
        logic            start;
        logic            sqrt;
        logic [31:0]     num;
        logic [32:0]     den;
        logic [CntW-1:0] steps;
    } t_iter_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [GainW-1:0] res;
    } t_iter_sts;

endpackage

>>> rtl/aks_iter.sv
module aks_iter
    import aks_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_iter_cmd i_cmd,
    output t_iter_sts o_sts
);

    logic [33:0]      r_rem;
    logic [GainW-1:0] r_q;
    logic [31:0]      r_op;
    logic [CntW-1:0]  r_cnt;
    logic             r_first;
    logic             r_sqrt;
    logic             r_busy;
    logic             r_done;
    logic [32:0]      r_den;

    logic [33:0] t_val;
    logic [33:0] t_sub;
    logic        ge;

    always_comb begin
        if (r_sqrt) begin
            t_val = {r_rem[31:0], r_op[31:30]};
            t_sub = {4'b0, r_q[27:0], 2'b01};
        end else begin
            t_val = r_first ? r_rem : {r_rem[32:0], 1'b0};
            t_sub = {1'b0, r_den};
        end
        ge = (t_val >= t_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_sqrt  <= i_cmd.sqrt;
                r_rem   <= i_cmd.sqrt ? '0 : {2'b0, i_cmd.num};
                r_op    <= i_cmd.num;
                r_den   <= i_cmd.den;
                r_q     <= '0;
                r_cnt   <= i_cmd.steps - 5'd1;
                r_first <= 1'b1;
            end else if (r_busy) begin
                r_rem   <= ge ? (t_val - t_sub) : t_val;
                r_q     <= {r_q[GainW-2:0], ge};
                r_op    <= {r_op[29:0], 2'b00};
                r_first <= 1'b0;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.res  = r_q;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy) else $error("iter start while busy");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("iter done while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("iter done without work");
`endif

endmodule

>>> rtl/adaptive_kalman_smoother_core.sv
// From input transfer to result valid, an item passes through the shared iterative
// unit for square root, normalise divide and gain divide, in that order; the
// normalise divide runs only when needed, and the gain divide only for a nonzero sum.
// One item is in work at a time; a new sample is taken only in the idle state.
// The finished result sits in an output register; a full one holds the last step.
// Reset (synchronous, active low) loads register defaults and filter state.
module adaptive_kalman_smoother_core
    import aks_pkg::*;
#(
    parameter logic signed [DataW-1:0] INIT_ESTIMATE = InitEstimateDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DataW-1:0]   s_axis_tdata,   // [31:0] sample
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DataW-1:0]   m_axis_tdata,   // [31:0] estimate
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic [31:0] r_meas_n, r_q_lo, r_q_hi, r_s_lo, r_s_hi, r_q_step;
    logic [15:0] r_var_w;

    logic [31:0]      r_est, r_ev, r_pn, r_rv, r_pp, r_sq, r_out;
    logic [32:0]      r_res, r_mag;
    logic [63:0]      r_acc, r_prod;
    logic [StdW-1:0]  r_std;
    logic [NormW-1:0] r_n;
    logic signed [34:0] r_dlt;
    logic [GainW-1:0] r_k;
    logic             r_out_valid;

    t_iter_cmd iter_cmd;
    t_iter_sts iter_sts;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] n_rv;
    logic [32:0] sum_s, q_diff;
    logic [31:0] q_abs;
    logic        norm_div;
    logic [NormW-1:0] norm_fix;
    logic        fin_go;

    aks_iter u_iter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (iter_cmd),
        .o_sts  (iter_sts)
    );

    assign mul_p  = 64'(mul_a) * 64'(mul_b);
    assign n_rv   = 32'((r_acc + r_prod) >> 16);
    assign sum_s  = {1'b0, r_pp} + {1'b0, r_meas_n};
    assign q_diff = {1'b0, r_q_hi} - {1'b0, r_q_lo};
    assign q_abs  = q_diff[32] ? 32'(-q_diff) : q_diff[31:0];
    assign fin_go = !r_out_valid || m_axis_tready;

    always_comb begin
        norm_div = 1'b0;
        norm_fix = '0;
        if (r_s_hi <= r_s_lo) begin
            norm_fix = ({4'b0, r_std} >= r_s_lo) ? 17'h10000 : '0;
        end else if ({4'b0, r_std} <= r_s_lo) begin
            norm_fix = '0;
        end else if ({4'b0, r_std} >= r_s_hi) begin
            norm_fix = 17'h10000;
        end else begin
            norm_div = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_SQ;
            S_SQ:   n_state = S_RVA;
            S_RVA:  n_state = S_RVB;
            S_RVB:  n_state = S_RVC;
            S_RVC:  n_state = S_SQRT;
            S_SQRT: if (iter_sts.done) n_state = S_NORM;
            S_NORM: n_state = norm_div ? S_NDIV : S_SM1;
            S_NDIV: if (iter_sts.done) n_state = S_SM1;
            S_SM1:  n_state = S_SM2;
            S_SM2:  n_state = S_SM3;
            S_SM3:  n_state = S_LIM1;
            S_LIM1: n_state = S_LIM2;
            S_LIM2: n_state = S_GAIN;
            S_GAIN: n_state = (sum_s == '0) ? S_XM1 : S_GDIV;
            S_GDIV: if (iter_sts.done) n_state = S_XM1;
            S_XM1:  n_state = S_XM2;
            S_XM2:  n_state = S_XN;
            S_XN:   n_state = S_EV;
            S_EV:   n_state = S_EU;
            S_EU:   n_state = S_FIN;
            S_FIN:  if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready  = (r_state == S_IDLE);
        iter_cmd       = '0;
        mul_a          = '0;
        mul_b          = '0;
        unique case (r_state)
            S_SQ: begin
                mul_a = {12'b0, r_mag[19:0]};
                mul_b = {12'b0, r_mag[19:0]};
            end
            S_RVA: begin
                mul_a = {16'b0, r_var_w};
                mul_b = r_rv;
            end
            S_RVB: begin
                mul_a = 32'(17'h10000 - {1'b0, r_var_w});
                mul_b = r_sq;
            end
            S_RVC: begin
                iter_cmd.start = 1'b1;
                iter_cmd.sqrt  = 1'b1;
                iter_cmd.num   = n_rv;
                iter_cmd.steps = SqrtSteps;
            end
            S_NORM: begin
                iter_cmd.start = norm_div;
                iter_cmd.num   = {4'b0, r_std} - r_s_lo;
                iter_cmd.den   = {1'b0, r_s_hi - r_s_lo};
                iter_cmd.steps = NormSteps;
            end
            S_SM1: begin
                mul_a = {15'b0, r_n};
                mul_b = {15'b0, r_n};
            end
            S_SM2: begin
                mul_a = {15'b0, r_prod[32:16]};
                mul_b = {14'b0, 18'h30000 - {r_n, 1'b0}};
            end
            S_SM3: begin
                mul_a = q_abs;
                mul_b = {15'b0, r_prod[32:16]};
            end
            S_GAIN: begin
                iter_cmd.start = (sum_s != '0);
                iter_cmd.num   = r_pp;
                iter_cmd.den   = sum_s;
                iter_cmd.steps = GainSteps;
            end
            S_XM1: begin
                mul_a = {1'b0, r_k};
                mul_b = {16'b0, r_mag[15:0]};
            end
            S_XM2: begin
                mul_a = {1'b0, r_k};
                mul_b = {15'b0, r_mag[32:16]};
            end
            S_EV: begin
                mul_a = {1'b0, 31'h40000000 - r_k};
                mul_b = r_pp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_n <= MeasNRst;
            r_q_lo   <= QLowRst;
            r_q_hi   <= QHighRst;
            r_s_lo   <= StdLowRst;
            r_s_hi   <= StdHighRst;
            r_q_step <= QStepRst;
            r_var_w  <= VarWRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegInitP: begin
                    // initial variance only takes effect at reset, from its default
                end
                RegMeasN:   r_meas_n <= i_cfg_data;
                RegQLow:    r_q_lo   <= i_cfg_data;
                RegQHigh:   r_q_hi   <= i_cfg_data;
                RegStdLow:  r_s_lo   <= i_cfg_data;
                RegStdHigh: r_s_hi   <= i_cfg_data;
                RegQStep:   r_q_step <= i_cfg_data;
                RegVarW:    r_var_w  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    logic [32:0]        pre_sum;
    logic [32:0]        pre_res;
    logic [31:0]        lim_t;
    logic signed [34:0] lim_tgt;
    logic signed [34:0] lim_dlt;
    logic signed [34:0] lim_q;
    logic [63:0]        xn_tot;
    logic [33:0]        xn_m;
    logic [34:0]        xn_x;

    always_comb begin
        pre_sum = {1'b0, r_ev} + {1'b0, r_pn};
        pre_res = {s_axis_tdata[31], s_axis_tdata} - {r_est[31], r_est};
        lim_t   = r_prod[47:16];
        lim_tgt = q_diff[32] ? ($signed({3'b0, r_q_lo}) - $signed({3'b0, lim_t}))
                             : ($signed({3'b0, r_q_lo}) + $signed({3'b0, lim_t}));
        lim_dlt = lim_tgt - $signed({3'b0, r_pn});
        if (lim_dlt > $signed({3'b0, r_q_step})) begin
            lim_dlt = $signed({3'b0, r_q_step});
        end
        if (lim_dlt < -$signed({3'b0, r_q_step})) begin
            lim_dlt = -$signed({3'b0, r_q_step});
        end
        lim_q = $signed({3'b0, r_pn}) + r_dlt;
        if (lim_q < $signed({3'b0, r_q_lo})) begin
            lim_q = $signed({3'b0, r_q_lo});
        end
        if (lim_q > $signed({3'b0, r_q_hi})) begin
            lim_q = $signed({3'b0, r_q_hi});
        end
        xn_tot = r_acc + {r_prod[47:0], 16'b0};
        xn_m   = xn_tot[63:30];
        xn_x   = {{3{r_est[31]}}, r_est} + (r_res[32] ? 35'(-{1'b0, xn_m})
                                                    : {1'b0, xn_m});
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_est       <= INIT_ESTIMATE;
            r_ev        <= InitPRst;
            r_pn        <= QLowRst;
            r_rv        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && fin_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_pp  <= pre_sum[32] ? '1 : pre_sum[31:0];
                        r_res <= pre_res;
                        r_mag <= pre_res[32] ? 33'(-pre_res) : pre_res;
                    end
                end
                S_RVA:  r_sq  <= (|r_mag[32:20]) ? '1 : r_prod[39:8];
                S_RVB:  r_acc <= r_prod;
                S_RVC:  r_rv  <= n_rv;
                S_SQRT: if (iter_sts.done) r_std <= iter_sts.res[StdW-1:0];
                S_NORM: r_n   <= norm_fix;
                S_NDIV: if (iter_sts.done) r_n <= iter_sts.res[NormW-1:0];
                S_LIM1: r_dlt <= lim_dlt;
                S_LIM2: r_pn  <= lim_q[31:0];
                S_GAIN: r_k   <= '0;
                S_GDIV: if (iter_sts.done) r_k <= iter_sts.res;
                S_XM2:  r_acc <= r_prod;
                S_XN:   r_est <= xn_x[31:0];
                S_EU:   r_ev  <= r_prod[61:30];
                S_FIN:  if (fin_go) r_out <= r_est;
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while item in work");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside final step");
    a_pn_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_pn) |-> ($past(r_state) == S_LIM2 || $past(!i_rst_n)))
        else $error("process noise changed out of sequence");
    a_iter_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_sts.busy |-> (r_state == S_SQRT || r_state == S_NDIV ||
                           r_state == S_GDIV))
        else $error("iterative unit busy outside wait state");
`endif

endmodule

>>> tb/tb_kalman_checker.sv
`timescale 1ns / 1ps

module tb_kalman_checker
    import aks_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [DataW-1:0] i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [DataW-1:0] i_out_data,
    input  logic             i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [31:0] cfg_regs [8];
    longint est_value;
    logic [31:0] err_var, proc_noise, resid_var;
    logic [31:0] estimates_due [$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] filter_sample(input logic [31:0] smp);
        longint x_pred, res, target, delta, q, x_new;
        longint unsigned mag, sq, pp, s, k, nrm, n2, sm, stdv;
        longint unsigned w, s_lo, s_hi, step;
        w = cfg_regs[RegVarW];
        s_lo = cfg_regs[RegStdLow];
        s_hi = cfg_regs[RegStdHigh];
        step = cfg_regs[RegQStep];
        x_pred = est_value;
        res = longint'($signed(smp)) - x_pred;
        mag = res < 0 ? -res : res;
        pp = longint'(err_var) + longint'(proc_noise);
        if (pp > 64'hFFFFFFFF) pp = 64'hFFFFFFFF;
        sq = (mag >= (64'd1 << 20)) ? 64'hFFFFFFFF : (mag * mag) >> 8;
        resid_var = 32'((w * resid_var + (65536 - w) * sq) >> 16);
        stdv = int_sqrt(longint'(resid_var) << 24);
        if (s_hi <= s_lo) nrm = (stdv >= s_lo) ? 65536 : 0;
        else if (stdv <= s_lo) nrm = 0;
        else if (stdv >= s_hi) nrm = 65536;
        else nrm = ((stdv - s_lo) << 16) / (s_hi - s_lo);
        n2 = (nrm * nrm) >> 16;
        sm = (n2 * (3 * 65536 - 2 * nrm)) >> 16;
        target = longint'(cfg_regs[RegQLow]) +
            ((longint'(cfg_regs[RegQHigh]) - longint'(cfg_regs[RegQLow])) * longint'(sm))
            / 65536;
        delta = target - longint'(proc_noise);
        if (delta > longint'(step)) delta = step;
        if (delta < -longint'(step)) delta = -longint'(step);
        q = longint'(proc_noise) + delta;
        if (q < longint'(cfg_regs[RegQLow])) q = cfg_regs[RegQLow];
        if (q > longint'(cfg_regs[RegQHigh])) q = cfg_regs[RegQHigh];
        proc_noise = 32'(q);
        s = pp + cfg_regs[RegMeasN];
        k = (s == 0) ? 0 : (pp << 30) / s;
        x_new = x_pred + (longint'(k) * res) / 64'sd1073741824;
        err_var = 32'(((64'd1073741824 - k) * pp) >> 30);
        est_value = x_new;
        return x_new[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            cfg_regs = '{InitPRst, MeasNRst, QLowRst, QHighRst,
                         StdLowRst, StdHighRst, QStepRst, {16'd0, VarWRst}};
            est_value = longint'(InitEstimateDef);
            err_var = InitPRst;
            proc_noise = QLowRst;
            resid_var = '0;
            estimates_due.delete();
        end else begin
            if (i_cfg_we)
                cfg_regs[i_cfg_idx] = (i_cfg_idx == RegVarW) ? {16'd0, i_cfg_data[15:0]}
                                                              : i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (estimates_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected estimate %h", i_out_data));
                end else begin
                    want = estimates_due.pop_front();
                    if (i_out_data !== want)
                        report_mismatch($sformatf("estimate %h, predicted %h",
                                                  i_out_data, want));
                end
            end
            if (i_in_valid && i_in_ready)
                estimates_due.push_back(filter_sample(i_in_data));
        end
        o_pending = estimates_due.size();
    end

endmodule

>>> tb/tb_adaptive_kalman_smoother_core.sv
`timescale 1ns / 1ps

module tb_adaptive_kalman_smoother_core;
    import aks_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    logic [31:0] s_data = '0, m_data;
    logic cfg_we = 0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    int fail_count, pending;
    int cycles = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    always #5 i_clk = ~i_clk;

    adaptive_kalman_smoother_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    tb_kalman_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    task automatic send_sample(input logic [31:0] smp);
        int gap;
        gap = $urandom_range(0, 3);
        repeat (gap) @(negedge i_clk);
        s_valid <= 1;
        s_data <= smp;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        s_valid <= 0;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    function automatic logic [31:0] noisy_sample();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8191)) - 4096);
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_ready <= 0;
            end else if (m_ready && m_valid) begin
                m_ready <= 0;
            end else if (!m_ready) begin
                gap = $urandom_range(0, 3);
                repeat (gap) @(negedge i_clk);
                if (!hold_off) m_ready <= 1;
            end
        end
    end

    initial begin
        logic [31:0] directed [$];
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        directed = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000,
                     32'h00000001, 32'hFFFFFFFF, 32'h0000FFFF, 32'h00100000,
                     32'hFFF00000, 32'h55555555, 32'hAAAAAAAA, 32'h0};
        foreach (directed[i]) send_sample(directed[i]);
        drain();
        // phase loop: extremes and random settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(RegInitP, 32'hFFFFFFFF);
                    write_reg(RegMeasN, 32'd1);
                    write_reg(RegVarW, 32'd0);
                end
                1: begin
                    write_reg(RegMeasN, 32'hFFFFFFFF);
                    write_reg(RegQLow, 32'd0);
                    write_reg(RegQHigh, 32'hFFFFFFFF);
                    write_reg(RegQStep, 32'hFFFFFFFF);
                    write_reg(RegVarW, 32'h1FFFF);
                end
                2: begin
                    write_reg(RegStdLow, 32'd100000);
                    write_reg(RegStdHigh, 32'd100000);
                    write_reg(RegQLow, 32'h01000000);
                    write_reg(RegQHigh, 32'h00100000);
                    write_reg(RegMeasN, 32'd167772);
                end
                3: begin
                    write_reg(RegStdLow, 32'hFFFFFFFF);
                    write_reg(RegStdHigh, 32'd0);
                    write_reg(RegQStep, 32'd0);
                    write_reg(RegInitP, 32'd0);
                end
                default: begin
                    for (int r = 0; r < 8; r++)
                        write_reg(r[CfgIdxW-1:0], $urandom());
                    if ($urandom_range(0, 1)) write_reg(RegMeasN, $urandom_range(1, 1 << 24));
                    write_reg(RegStdLow, $urandom_range(0, 1 << 20));
                    write_reg(RegStdHigh, $urandom_range(1 << 20, 1 << 28));
                end
            endcase
            for (int n = 0; n < 160; n++) begin
                if (ph == 4 && n == 10) hold_off = 1;
                if (ph == 4 && n == 14) hold_off = 0;
                send_sample(noisy_sample());
            end
            drain();
        end
        stim_done = 1;
    end

    // long receiver stall, counted in cycles of its own
    initial begin
        wait (hold_off);
        repeat (600) @(negedge i_clk);
        hold_off = 0;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
